// File: rtl/eased_multichannel_ramp_assert.svh
// Assertion macros used by the checker file.
`ifndef EASED_MULTICHANNEL_RAMP_ASSERT_SVH
`define EASED_MULTICHANNEL_RAMP_ASSERT_SVH

`define EMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define EMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/emr_pkg.sv
package emr_pkg;

  localparam int PORTS_DEF = 4;
  localparam int DIV_DW    = 48;
  localparam int DIV_VW    = 30;
  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam logic [15:0] TWO_Q14 = 16'd32768;

  typedef struct packed {
    logic               active;
    logic               ease;
    logic               fall;
    logic [16:0]        phase;
    logic [31:0]        elapsed;
    logic [15:0]        dur;
    logic signed [15:0] start_a;
    logic signed [15:0] end_a;
    logic signed [15:0] cur;
  } chan_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quot;
    logic              rem_nz;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SWR, S_TRD, S_TCHK, S_RDIV, S_ELAP,
    S_SNAP, S_MUL, S_IDIV, S_WB, S_OUT
  } state_t;

endpackage

// File: rtl/emr_div.sv
module emr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  emr_pkg::div_req_t req,
  output emr_pkg::div_rsp_t rsp
);
  import emr_pkg::*;

  localparam int CNTW = $clog2(DIV_DW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] quo_r, quo_nxt;
  logic [DIV_VW-1:0] rem_r, rem_nxt;
  logic [DIV_VW-1:0] dvs_r, dvs_nxt;
  logic [DIV_VW:0]   shifted;
  logic [DIV_VW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    shifted  = {rem_r, quo_r[DIV_DW-1]};
    trial    = shifted - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[DIV_VW]) begin
        rem_nxt = trial[DIV_VW-1:0];
        quo_nxt = {quo_r[DIV_DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_VW-1:0];
        quo_nxt = {quo_r[DIV_DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(DIV_DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.quot   = quo_r;
  assign rsp.rem_nz = |rem_r;

endmodule

// File: rtl/eased_multichannel_ramp.sv
// Bank of PORTS x 3 eased setpoint ramps (pitch, yaw, roll for each port).
// Input channel: in_valid/in_stall. A start transaction (in_command 0) arms
// a glide on one channel (read, then write) and gives no result. A tick
// transaction (in_command 1) walks every channel in order, port-major then
// axis, and gives one result per channel, in_stall staying high until the
// last result (out_last) has been taken.
// Per channel a tick reads and checks the channel; an idle channel goes
// straight to its result. A gliding one gets its speed ratio from the
// shared restoring divider when easing mid-phase, advances its elapsed time,
// then snaps to the target or divides again to interpolate, and is written back.
// Output channel: out_valid/out_stall. The result stays registered and
// steady while out_stall is high; the walk resumes once it is taken.
// Reset (rst_n low, synchronous) clears all channels to idle at angle zero.
// The channel store needs no clearing pass.
module eased_multichannel_ramp #(
  parameter int PORTS = emr_pkg::PORTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [1:0]         in_port,
  input  logic [1:0]         in_axis,
  input  logic [15:0]        in_duration_ms,
  input  logic signed [15:0] in_target_angle,
  input  logic [9:0]         in_frame_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_port,
  output logic [1:0]         out_axis,
  output logic signed [15:0] out_angle,
  output logic               out_busy_res,
  output logic               out_last
);
  import emr_pkg::*;

  localparam int NCH = PORTS * 3;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;

  state_t state_r, state_nxt;

  chan_t           mem [NCH];
  logic [NCH-1:0]  written_r;
  chan_t           rd_q_r;
  logic            rd_v_r;
  logic [CW-1:0]   ra;
  logic            mem_we;
  chan_t           mem_wd;
  logic [CW-1:0]   mem_wa;

  logic [CW-1:0]   ch_r;
  logic [1:0]      port_r;
  logic [1:0]      axis_r;
  logic [CW-1:0]   sidx_r;
  logic [15:0]     sdur_r;
  logic [15:0]     stgt_r;
  logic [9:0]      frame_r;
  chan_t           wk_r;
  logic [15:0]     r_r;
  logic [46:0]     prod_r;
  logic            neg_r;
  logic signed [15:0] oangle_r;
  logic            obusy_r;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [5:0]  sidx_full;
  logic        sidx_ok;
  chan_t       c;
  logic        ease_path;
  logic [16:0] ph;
  logic        over;
  logic        need_div;
  logic        is_last;
  logic [31:0] elap_nxt;
  logic        snap;
  logic signed [16:0] diff;
  logic [16:0] mag;
  logic [15:0] ceil_q;
  chan_t       tchk_wk;
  logic [15:0] tchk_r;
  chan_t       snap_wk;

  emr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    sidx_full = 6'({in_port, 1'b0}) + 6'(in_port) + 6'(in_axis);
    sidx_ok   = (in_axis <= 2'd2) && (6'(in_port) < 6'(PORTS));
    c         = rd_v_r ? rd_q_r : '0;
    ease_path = c.active && c.ease && (c.dur != 16'd0);
    ph        = c.phase + 17'(frame_r);
    over      = {ph, 1'b0} > 18'(c.dur);
    need_div  = ease_path && !over;
    is_last   = (ch_r == CW'(NCH - 1));
    elap_nxt  = wk_r.elapsed + (32'(frame_r) * 32'(r_r));
    snap      = (wk_r.dur == 16'd0) || (wk_r.elapsed >= {2'b00, wk_r.dur, 14'd0});
    diff      = {wk_r.end_a[15], wk_r.end_a} - {wk_r.start_a[15], wk_r.start_a};
    mag       = diff[16] ? 17'(-diff) : 17'(diff);
    ceil_q    = drsp.quot[15:0] + 16'(drsp.rem_nz);
    tchk_wk   = c;
    tchk_r    = ONE_Q14;
    if (ease_path) begin
      tchk_wk.phase = over ? 17'd0 : ph;
      if (over) begin
        tchk_wk.fall = !c.fall;
        tchk_r       = c.fall ? 16'd0 : TWO_Q14;
      end
    end
    snap_wk = wk_r;
    if (snap) begin
      snap_wk.cur    = wk_r.end_a;
      snap_wk.active = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command) begin
            state_nxt = S_TRD;
          end else if (sidx_ok) begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD:  state_nxt = S_SWR;
      S_SWR:  state_nxt = S_IDLE;
      S_TRD:  state_nxt = S_TCHK;
      S_TCHK: begin
        if (!c.active) begin
          state_nxt = S_OUT;
        end else if (need_div) begin
          state_nxt = S_RDIV;
        end else begin
          state_nxt = S_ELAP;
        end
      end
      S_RDIV: if (drsp.done) state_nxt = S_ELAP;
      S_ELAP: state_nxt = S_SNAP;
      S_SNAP: state_nxt = snap ? S_WB : S_MUL;
      S_MUL:  state_nxt = S_IDIV;
      S_IDIV: if (drsp.done) state_nxt = S_WB;
      S_WB:   state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = is_last ? S_IDLE : S_TRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != S_IDLE);
    out_valid     = (state_r == S_OUT);
    ra            = (state_r == S_SRD) ? sidx_r : ch_r;
    mem_we        = (state_r == S_SWR) || (state_r == S_WB);
    mem_wa        = (state_r == S_SWR) ? sidx_r : ch_r;
    mem_wd        = wk_r;
    if (state_r == S_SWR) begin
      mem_wd.active  = 1'b1;
      mem_wd.ease    = sdur_r > 16'({frame_r, 1'b0});
      mem_wd.fall    = 1'b0;
      mem_wd.phase   = '0;
      mem_wd.elapsed = '0;
      mem_wd.dur     = sdur_r;
      mem_wd.start_a = c.cur;
      mem_wd.end_a   = stgt_r;
      mem_wd.cur     = c.cur;
    end
    dreq.start    = 1'b0;
    dreq.dividend = {15'd0, ph, 16'd0};
    dreq.divisor  = 30'(c.dur);
    if (state_r == S_TCHK) begin
      dreq.start = need_div;
    end else if (state_r == S_MUL) begin
      dreq.start    = 1'b1;
      dreq.dividend = 48'(prod_r);
      dreq.divisor  = {wk_r.dur, 14'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      written_r <= '0;
      rd_v_r    <= 1'b0;
      ch_r      <= '0;
      port_r    <= '0;
      axis_r    <= '0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= written_r[ra];
      if (mem_we) begin
        written_r[mem_wa] <= 1'b1;
      end
      if (state_r == S_IDLE && in_valid && in_command) begin
        ch_r   <= '0;
        port_r <= '0;
        axis_r <= '0;
      end else if (state_r == S_OUT && !out_stall && !is_last) begin
        ch_r <= ch_r + 1'b1;
        if (axis_r == 2'd2) begin
          axis_r <= '0;
          port_r <= port_r + 1'b1;
        end else begin
          axis_r <= axis_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        sidx_r  <= sidx_full[CW-1:0];
        sdur_r  <= in_duration_ms;
        stgt_r  <= in_target_angle;
        frame_r <= in_frame_ms;
      end
      S_TCHK: begin
        wk_r     <= tchk_wk;
        oangle_r <= c.cur;
        obusy_r  <= 1'b0;
        r_r      <= tchk_r;
      end
      S_RDIV: begin
        if (drsp.done) begin
          r_r <= wk_r.fall ? (TWO_Q14 - ceil_q) : drsp.quot[15:0];
        end
      end
      S_ELAP: wk_r.elapsed <= elap_nxt;
      S_SNAP: begin
        wk_r   <= snap_wk;
        prod_r <= 47'(mag) * 47'(wk_r.elapsed[29:0]);
        neg_r  <= diff[16];
      end
      S_IDIV: begin
        if (drsp.done) begin
          wk_r.cur <= neg_r ? (wk_r.start_a - drsp.quot[15:0])
                            : (wk_r.start_a + drsp.quot[15:0]);
        end
      end
      S_WB: begin
        oangle_r <= wk_r.cur;
        obusy_r  <= wk_r.active;
      end
      default: ;
    endcase
  end

  assign out_port     = port_r;
  assign out_axis     = axis_r;
  assign out_angle    = oangle_r;
  assign out_busy_res = obusy_r;
  assign out_last     = is_last;

endmodule

// File: rtl/emr_checker.sv
module emr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_command,
  input logic [1:0]         in_port,
  input logic [1:0]         in_axis,
  input logic [15:0]        in_duration_ms,
  input logic signed [15:0] in_target_angle,
  input logic [9:0]         in_frame_ms,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_port,
  input logic [1:0]         out_axis,
  input logic signed [15:0] out_angle,
  input logic               out_busy_res,
  input logic               out_last
);
`include "eased_multichannel_ramp_assert.svh"

  // A stalled result transaction must hold.
  `EMR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_angle), "result changed while stalled")
  // Results are only shown while a tick is being walked.
  `EMR_ASSERT_NOW(a_busy, out_valid, in_stall, "result shown while input side ready")
  // The walk continues after a result that is not the last one.
  `EMR_ASSERT_NEXT(a_walk, out_valid && !out_stall && !out_last, in_stall, "tick walk ended early")
  `EMR_ASSERT_NOW(a_axis, out_valid, out_axis != 2'd3, "axis out of range")

endmodule

bind eased_multichannel_ramp emr_checker u_emr_checker (.*);
